// ===== rtl/core/efg_pkg.sv =====
// efg_pkg: shared types, constants and Q16.16 helpers for the element field gradient block.
// No dependencies; imported by every module under rtl/core.
package efg_pkg;

    // register indexes on the configuration port
    localparam logic REG_DIMENSIONS = 1'b0;
    localparam logic REG_VARS       = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_COORD = 2'd0;
    localparam logic [1:0] KIND_JAC   = 2'd1;
    localparam logic [1:0] KIND_INV   = 2'd2;
    localparam logic [1:0] KIND_VAR   = 2'd3;

    localparam logic signed [31:0] ONE_Q16 = 32'sh0001_0000;
    localparam logic signed [31:0] Q_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN   = 32'sh8000_0000;
    localparam logic signed [63:0] A_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] A_MIN   = 64'sh8000_0000_0000_0000;

    localparam int DIV_STEPS = 48;
    localparam int NUM_STEPS = 18;
    localparam int VAR_STEP0 = 12;

    typedef struct packed {
        logic [1:0] dims;   // effective, 1..3
        logic [3:0] nvars;  // effective, 1..var capacity
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] sv;
        logic signed [31:0] d0;
        logic signed [31:0] d1;
        logic signed [31:0] d2;
        logic signed [31:0] nx;
        logic signed [31:0] ny;
        logic signed [31:0] nz;
        logic signed [31:0] val;
        logic signed [31:0] rate;
        logic signed [31:0] acc;
        logic [2:0]         vidx;
        logic               first;
        logic               accum;
        logic               last;
    } item_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [2:0]         row_index;
        logic signed [31:0] val_a;
        logic signed [31:0] val_b;
        logic signed [31:0] val_c;
        logic signed [31:0] val_d;
        logic signed [31:0] val_e;
        logic signed [31:0] val_f;
        logic               last;
    } result_t;

    typedef enum logic [3:0] {
        BK_IDLE, BK_MUL, BK_ADD, BK_CONV, BK_FMUL, BK_FADD,
        BK_DIV, BK_DIVW, BK_EMIT, BK_VLOAD, BK_VEMIT
    } back_state_t;

    typedef enum logic [1:0] {PH_COF, PH_DET, PH_MAP} phase_t;

    typedef enum logic [3:0] {
        OP_SV, OP_D0, OP_D1, OP_D2, OP_NX, OP_NY, OP_NZ, OP_VAL, OP_RATE, OP_ACC
    } opsel_t;

    // product schedule of one item: coords, Jacobian (row-major), then variable sums
    localparam opsel_t STEP_A [NUM_STEPS] = '{
        OP_SV, OP_SV, OP_SV,
        OP_D0, OP_D1, OP_D2, OP_D0, OP_D1, OP_D2, OP_D0, OP_D1, OP_D2,
        OP_SV, OP_SV, OP_SV, OP_D0, OP_D1, OP_D2
    };
    localparam opsel_t STEP_B [NUM_STEPS] = '{
        OP_NX, OP_NY, OP_NZ,
        OP_NX, OP_NX, OP_NX, OP_NY, OP_NY, OP_NY, OP_NZ, OP_NZ, OP_NZ,
        OP_VAL, OP_RATE, OP_ACC, OP_VAL, OP_VAL, OP_VAL
    };

    // 3x3 adjugate entry k = a[P]*a[Q] - a[R]*a[S]
    localparam logic [3:0] COF_P [9] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
    localparam logic [3:0] COF_Q [9] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
    localparam logic [3:0] COF_R [9] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
    localparam logic [3:0] COF_S [9] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            return s[64] ? A_MIN : A_MAX;
        end
        return s[63:0];
    endfunction

    // round half up, floor shift, saturate to Q16.16
    function automatic logic signed [31:0] to_q16(input logic signed [63:0] v);
        logic signed [63:0] r;
        logic signed [47:0] s;
        r = sat_add64(v, 64'sd32768);
        s = r[63:16];
        if (s > 48'sd2147483647) begin
            return Q_MAX;
        end
        if (s < -48'sd2147483648) begin
            return Q_MIN;
        end
        return s[31:0];
    endfunction

    function automatic logic signed [31:0] neg32(input logic signed [31:0] v);
        return (v == Q_MIN) ? Q_MAX : -v;
    endfunction

    function automatic logic signed [31:0] field_sel(input item_t it, input opsel_t s);
        logic signed [31:0] r;
        case (s)
            OP_SV:   r = it.sv;
            OP_D0:   r = it.d0;
            OP_D1:   r = it.d1;
            OP_D2:   r = it.d2;
            OP_NX:   r = it.nx;
            OP_NY:   r = it.ny;
            OP_NZ:   r = it.nz;
            OP_VAL:  r = it.val;
            OP_RATE: r = it.rate;
            OP_ACC:  r = it.acc;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/element_field_gradient_top.sv =====
// element_field_gradient_top: isoparametric interpolation, Jacobian inverse and field gradients.
// Depends on efg_pkg, efg_front, efg_queue, efg_back (and efg_div below it).
//
//  channel   direction  handshake               payload
//  s_*       in         s_valid / s_ready       shape, coords, variable value/rate/accel, last
//  m_*       out        m_valid / m_ready       kind, row_index, val_a..val_f, last
//  cfg_*     in         cfg_wr_en (no stall)    cfg_index, cfg_wr_data
//
// Work: an item on the first variable of a node runs all 18 products in the back (through
// the one shared 32x32 multiplier, a multiply state and an accumulate state each), any other
// item only the 6 variable products. The last item adds the finish: cofactors and determinant
// in 3D, up to 9 serial divisions, then 2*dims+1 results and per variable a gradient mapping
// and one result. The shared multiplier and the bit-serial divider set the pace of the block.
// Reset: aresetn is synchronous, active low; it clears counters, accumulators and the queue.
// Stalls: a two-deep queue lets the front accept while the back works; the output register
// holds a result while the back goes on to its next item.
module element_field_gradient_top #(
    parameter int MAX_NODES = 32,
    parameter int MAX_VARS  = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic               cfg_index,
    input  logic [3:0]         cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_shape_value,
    input  logic signed [31:0] s_shape_d0,
    input  logic signed [31:0] s_shape_d1,
    input  logic signed [31:0] s_shape_d2,
    input  logic signed [31:0] s_node_x,
    input  logic signed [31:0] s_node_y,
    input  logic signed [31:0] s_node_z,
    input  logic signed [31:0] s_var_value,
    input  logic signed [31:0] s_var_rate,
    input  logic signed [31:0] s_var_accel,
    input  logic               s_last_of_element,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_kind,
    output logic [2:0]         m_row_index,
    output logic signed [31:0] m_val_a,
    output logic signed [31:0] m_val_b,
    output logic signed [31:0] m_val_c,
    output logic signed [31:0] m_val_d,
    output logic signed [31:0] m_val_e,
    output logic signed [31:0] m_val_f,
    output logic               m_last
);
    import efg_pkg::*;

    // variable slots never exceed the 3-bit row index
    localparam int VAR_CAP = (MAX_VARS < 8) ? MAX_VARS : 8;

    logic [1:0] dims_reg;
    logic [3:0] vars_reg;
    cfg_t       cfg;
    logic       q_full, q_push, q_valid, q_pop;
    item_t      push_item, head_item;
    result_t    res;

    // configuration registers; the user must write them only while idle, the block does not enforce it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dims_reg <= 2'd3;
            vars_reg <= 4'd3;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_DIMENSIONS: dims_reg <= cfg_wr_data[1:0];
                REG_VARS:       vars_reg <= cfg_wr_data;
                default:        vars_reg <= vars_reg;
            endcase
        end
    end

    // effective settings: zero dimensions acts as a line, zero variables as one, count clamped to capacity
    always_comb begin
        cfg.dims = (dims_reg == 2'd0) ? 2'd1 : dims_reg;
        if (vars_reg == 4'd0) begin
            cfg.nvars = 4'd1;
        end else if (vars_reg > 4'(VAR_CAP)) begin
            cfg.nvars = 4'(VAR_CAP);
        end else begin
            cfg.nvars = vars_reg;
        end
    end

    efg_front #(
        .MAX_NODES (MAX_NODES)
    ) u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_shape_value     (s_shape_value),
        .s_shape_d0        (s_shape_d0),
        .s_shape_d1        (s_shape_d1),
        .s_shape_d2        (s_shape_d2),
        .s_node_x          (s_node_x),
        .s_node_y          (s_node_y),
        .s_node_z          (s_node_z),
        .s_var_value       (s_var_value),
        .s_var_rate        (s_var_rate),
        .s_var_accel       (s_var_accel),
        .s_last_of_element (s_last_of_element),
        .q_full            (q_full),
        .q_push            (q_push),
        .q_item            (push_item)
    );

    efg_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (head_item)
    );

    efg_back #(
        .VAR_CAP (VAR_CAP)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_item    (head_item),
        .q_pop     (q_pop),
        .out_ready (m_ready),
        .out_valid (m_valid),
        .out_res   (res)
    );

    assign m_kind      = res.kind;
    assign m_row_index = res.row_index;
    assign m_val_a     = res.val_a;
    assign m_val_b     = res.val_b;
    assign m_val_c     = res.val_c;
    assign m_val_d     = res.val_d;
    assign m_val_e     = res.val_e;
    assign m_val_f     = res.val_f;
    assign m_last      = res.last;

`ifndef NO_ASSERTIONS
    // the queue never takes a transfer it has no room for
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("queue overflow");

    // only the final variable result closes an element
    a_last_is_var: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> m_kind == KIND_VAR)
        else $error("last flag on a non-variable result");

    // coordinate results always carry row zero
    a_coord_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_COORD |-> m_row_index == 3'd0)
        else $error("coordinate result with nonzero row");

    // the back pops only an entry that is present
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("pop from empty queue");
`endif

endmodule

// ===== rtl/core/efg_front.sv =====
// efg_front: accepts input transfers, tracks variable and node position, tags each item.
// Depends on efg_pkg.
module efg_front #(
    parameter int MAX_NODES = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  efg_pkg::cfg_t      cfg,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_shape_value,
    input  logic signed [31:0] s_shape_d0,
    input  logic signed [31:0] s_shape_d1,
    input  logic signed [31:0] s_shape_d2,
    input  logic signed [31:0] s_node_x,
    input  logic signed [31:0] s_node_y,
    input  logic signed [31:0] s_node_z,
    input  logic signed [31:0] s_var_value,
    input  logic signed [31:0] s_var_rate,
    input  logic signed [31:0] s_var_accel,
    input  logic               s_last_of_element,
    input  logic               q_full,
    output logic               q_push,
    output efg_pkg::item_t     q_item
);
    import efg_pkg::*;

    localparam int NCW = $clog2(MAX_NODES + 1);

    logic [2:0]     var_cnt_reg, var_cnt_next;
    logic [NCW-1:0] node_cnt_reg, node_cnt_next;
    logic [2:0]     j;
    logic [3:0]     j_inc;
    logic           accum;

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready;

    // a counter left beyond a shrunken variable count starts a new node
    assign j     = ({1'b0, var_cnt_reg} >= cfg.nvars) ? 3'd0 : var_cnt_reg;
    assign j_inc = {1'b0, j} + 4'd1;
    assign accum = node_cnt_reg < NCW'(MAX_NODES);

    always_comb begin
        q_item.sv    = s_shape_value;
        q_item.d0    = s_shape_d0;
        q_item.d1    = s_shape_d1;
        q_item.d2    = s_shape_d2;
        q_item.nx    = s_node_x;
        q_item.ny    = s_node_y;
        q_item.nz    = s_node_z;
        q_item.val   = s_var_value;
        q_item.rate  = s_var_rate;
        q_item.acc   = s_var_accel;
        q_item.vidx  = j;
        q_item.first = (j == 3'd0);
        q_item.accum = accum;
        q_item.last  = s_last_of_element;
    end

    always_comb begin
        var_cnt_next  = var_cnt_reg;
        node_cnt_next = node_cnt_reg;
        if (q_push) begin
            if (s_last_of_element) begin
                var_cnt_next  = '0;
                node_cnt_next = '0;
            end else if (j_inc >= cfg.nvars) begin
                var_cnt_next = '0;
                if (accum) begin
                    node_cnt_next = node_cnt_reg + NCW'(1);
                end
            end else begin
                var_cnt_next = j_inc[2:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            var_cnt_reg  <= '0;
            node_cnt_reg <= '0;
        end else begin
            var_cnt_reg  <= var_cnt_next;
            node_cnt_reg <= node_cnt_next;
        end
    end

endmodule

// ===== rtl/core/efg_queue.sv =====
// efg_queue: two-entry item queue between the front and the back.
// Depends on efg_pkg.
module efg_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  efg_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output efg_pkg::item_t head
);
    import efg_pkg::*;

    item_t      mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full  = (count_reg == 2'd2);
    assign valid = (count_reg != 2'd0);
    assign head  = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/core/efg_div.sv =====
// efg_div: serial signed divider, (num * 2^16) / den truncated toward zero and saturated.
// Depends on efg_pkg; one quotient bit per cycle.
module efg_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [31:0] num,
    input  logic signed [31:0] den,
    output logic               done,
    output logic signed [31:0] quot
);
    import efg_pkg::*;

    logic        busy_reg, done_reg, neg_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] rem_reg, dmag_reg;
    logic [47:0] quo_reg;
    logic [31:0] nmag, dmag;
    logic [32:0] r2, diff;
    logic        ge;

    assign nmag = num[31] ? (~num + 32'd1) : num;
    assign dmag = den[31] ? (~den + 32'd1) : den;
    assign r2   = {rem_reg, quo_reg[47]};
    assign diff = r2 - {1'b0, dmag_reg};
    assign ge   = (r2 >= {1'b0, dmag_reg});
    assign done = done_reg;

    always_comb begin
        if (neg_reg) begin
            quot = (quo_reg > 48'h0000_8000_0000) ? Q_MIN : -(quo_reg[31:0]);
        end else begin
            quot = (quo_reg > 48'h0000_7FFF_FFFF) ? Q_MAX : quo_reg[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'(DIV_STEPS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= '0;
            quo_reg  <= {nmag, 16'h0000};
            dmag_reg <= dmag;
            neg_reg  <= num[31] ^ den[31];
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[31:0] : r2[31:0];
            quo_reg <= {quo_reg[46:0], ge};
        end
    end

endmodule

// ===== rtl/core/efg_back.sv =====
// efg_back: accumulation through one shared multiplier, then inversion, mapping and results.
// Depends on efg_pkg and efg_div.
module efg_back #(
    parameter int VAR_CAP = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  efg_pkg::cfg_t    cfg,
    input  logic             q_valid,
    input  efg_pkg::item_t   q_item,
    output logic             q_pop,
    input  logic             out_ready,
    output logic             out_valid,
    output efg_pkg::result_t out_res
);
    import efg_pkg::*;

    localparam int VW = (VAR_CAP > 1) ? $clog2(VAR_CAP) : 1;

    back_state_t        state_reg, state_next;
    item_t              cur_reg;
    logic [4:0]         step_reg;
    logic signed [63:0] prod_reg;
    logic               prod_neg_reg;
    logic signed [63:0] geo_reg [12];
    logic signed [63:0] var_mem [VAR_CAP][6];
    logic [VAR_CAP-1:0] var_valid_reg;
    logic signed [31:0] a_reg [9];
    logic signed [31:0] adj_reg [9];
    logic signed [31:0] inv_reg [9];
    logic signed [31:0] g_reg [3];
    logic signed [31:0] vq_reg [3];
    logic signed [31:0] m_reg [3];
    logic signed [31:0] xq_reg [3];
    logic signed [31:0] det_reg;
    phase_t             phase_reg;
    logic [3:0]         idx_reg;
    logic [1:0]         term_reg;
    logic signed [63:0] facc_reg;
    logic [1:0]         kind_reg, row_reg;
    logic [2:0]         vj_reg;
    result_t            res_reg;
    logic               out_valid_reg;

    logic               out_free, step_last, fin_neg, fin_last_term, div_skip;
    logic               div_start, div_done, emit_geo, emit_var, var_last;
    logic [1:0]         dm1, nterms;
    logic [3:0]         t3, r3;
    logic [VW-1:0]      var_addr;
    logic [2:0]         fld;
    logic signed [63:0] var_rd [6];
    logic signed [63:0] acc_old, acc_new, facc_new;
    logic signed [31:0] fin_a, fin_b, mul_a, mul_b, fq, div_q;
    logic signed [31:0] row_src [9];
    logic signed [31:0] re0, re1, re2;

    assign out_free = !out_valid_reg || out_ready;
    assign dm1      = cfg.dims - 2'd1;
    assign step_last = (step_reg == 5'(NUM_STEPS - 1));
    assign fld      = 3'(step_reg - 5'(VAR_STEP0));
    assign var_addr = (state_reg == BK_ADD) ? cur_reg.vidx[VW-1:0] : vj_reg[VW-1:0];
    assign var_last = ({1'b0, vj_reg} == cfg.nvars - 4'd1);
    assign t3       = {2'b00, term_reg} + {1'b0, term_reg, 1'b0};
    assign r3       = {2'b00, row_reg} + {1'b0, row_reg, 1'b0};

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            var_rd[k] = var_valid_reg[var_addr] ? var_mem[var_addr][k] : '0;
        end
    end

    // operands of the finishing multiply-accumulate
    always_comb begin
        fin_neg = 1'b0;
        nterms  = 2'd2;
        fin_a   = '0;
        fin_b   = '0;
        case (phase_reg)
            PH_COF: begin
                if (term_reg == 2'd0) begin
                    fin_a = a_reg[COF_P[idx_reg]];
                    fin_b = a_reg[COF_Q[idx_reg]];
                end else begin
                    fin_a   = a_reg[COF_R[idx_reg]];
                    fin_b   = a_reg[COF_S[idx_reg]];
                    fin_neg = 1'b1;
                end
            end
            PH_DET: begin
                nterms = 2'd3;
                fin_a  = a_reg[{2'b00, term_reg}];
                fin_b  = adj_reg[t3];
            end
            PH_MAP: begin
                nterms = cfg.dims;
                fin_a  = inv_reg[t3 + idx_reg];
                fin_b  = g_reg[term_reg];
            end
            default: begin
                nterms = 2'd2;
            end
        endcase
    end

    assign fin_last_term = (term_reg == nterms - 2'd1);
    assign mul_a    = (state_reg == BK_MUL) ? field_sel(cur_reg, STEP_A[step_reg]) : fin_a;
    assign mul_b    = (state_reg == BK_MUL) ? field_sel(cur_reg, STEP_B[step_reg]) : fin_b;
    assign acc_old  = (step_reg < 5'(VAR_STEP0)) ? geo_reg[step_reg[3:0]] : var_rd[fld];
    assign acc_new  = sat_add64(acc_old, prod_reg);
    assign facc_new = sat_add64(facc_reg, prod_neg_reg ? -prod_reg : prod_reg);
    assign fq       = to_q16(facc_new);
    assign div_skip = (det_reg == '0) || (adj_reg[idx_reg] == '0);

    // result rows: Jacobian or inverse, entries beyond the dimensions read zero
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            row_src[k] = (kind_reg == KIND_JAC) ? a_reg[k] : inv_reg[k];
        end
        re0 = row_src[r3];
        re1 = (cfg.dims >= 2'd2) ? row_src[r3 + 4'd1] : '0;
        re2 = (cfg.dims == 2'd3) ? row_src[r3 + 4'd2] : '0;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    if (q_item.accum) begin
                        state_next = BK_MUL;
                    end else if (q_item.last) begin
                        state_next = BK_CONV;
                    end
                end
            end
            BK_MUL: state_next = BK_ADD;
            BK_ADD: begin
                if (!step_last) begin
                    state_next = BK_MUL;
                end else if (cur_reg.last) begin
                    state_next = BK_CONV;
                end else begin
                    state_next = BK_IDLE;
                end
            end
            BK_CONV: state_next = (cfg.dims == 2'd1) ? BK_DIV : BK_FMUL;
            BK_FMUL: state_next = BK_FADD;
            BK_FADD: begin
                if (!fin_last_term) begin
                    state_next = BK_FMUL;
                end else begin
                    case (phase_reg)
                        PH_COF: state_next = (cfg.dims == 2'd3) ? BK_FMUL : BK_DIV;
                        PH_DET: state_next = BK_DIV;
                        PH_MAP: begin
                            state_next = ({2'b00, idx_reg} + 6'd1 < {4'b0, cfg.dims}) ?
                                         BK_FMUL : BK_VEMIT;
                        end
                        default: state_next = BK_DIV;
                    endcase
                end
            end
            BK_DIV: begin
                if (!div_skip) begin
                    state_next = BK_DIVW;
                end else if (idx_reg == 4'd8) begin
                    state_next = BK_EMIT;
                end
            end
            BK_DIVW: begin
                if (div_done) begin
                    state_next = (idx_reg == 4'd8) ? BK_EMIT : BK_DIV;
                end
            end
            BK_EMIT: begin
                if (out_free && kind_reg == KIND_INV && row_reg == dm1) begin
                    state_next = BK_VLOAD;
                end
            end
            BK_VLOAD: state_next = BK_FMUL;
            BK_VEMIT: begin
                if (out_free) begin
                    state_next = var_last ? BK_IDLE : BK_VLOAD;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        q_pop     = (state_reg == BK_IDLE) && q_valid;
        div_start = (state_reg == BK_DIV) && !div_skip;
        emit_geo  = (state_reg == BK_EMIT) && out_free;
        emit_var  = (state_reg == BK_VEMIT) && out_free;
    end

    efg_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (adj_reg[idx_reg]),
        .den     (det_reg),
        .done    (div_done),
        .quot    (div_q)
    );

    // control state and the element accumulators, which reset and each element clear
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            var_valid_reg <= '0;
            for (int k = 0; k < 12; k++) begin
                geo_reg[k] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (emit_geo || emit_var) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == BK_ADD) begin
                if (step_reg < 5'(VAR_STEP0)) begin
                    geo_reg[step_reg[3:0]] <= acc_new;
                end else begin
                    var_valid_reg[var_addr] <= 1'b1;
                end
            end
            if (emit_var && var_last) begin
                var_valid_reg <= '0;
                for (int k = 0; k < 12; k++) begin
                    geo_reg[k] <= '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            BK_IDLE: begin
                if (q_pop) begin
                    cur_reg  <= q_item;
                    step_reg <= q_item.first ? 5'd0 : 5'(VAR_STEP0);
                end
            end
            BK_MUL, BK_FMUL: begin
                prod_reg     <= mul_a * mul_b;
                prod_neg_reg <= (state_reg == BK_FMUL) && fin_neg;
            end
            BK_ADD: begin
                if (step_reg >= 5'(VAR_STEP0)) begin
                    for (int k = 0; k < 6; k++) begin
                        var_mem[var_addr][k] <= (3'(k) == fld) ? acc_new : var_rd[k];
                    end
                end
                step_reg <= step_reg + 5'd1;
            end
            BK_CONV: begin
                for (int k = 0; k < 9; k++) begin
                    a_reg[k]   <= to_q16(geo_reg[3 + k]);
                    adj_reg[k] <= '0;
                    inv_reg[k] <= '0;
                end
                for (int k = 0; k < 3; k++) begin
                    xq_reg[k] <= to_q16(geo_reg[k]);
                end
                facc_reg  <= '0;
                term_reg  <= '0;
                phase_reg <= PH_COF;
                kind_reg  <= KIND_COORD;
                row_reg   <= '0;
                vj_reg    <= '0;
                idx_reg   <= (cfg.dims == 2'd2) ? 4'd8 : 4'd0;
                if (cfg.dims == 2'd1) begin
                    det_reg    <= to_q16(geo_reg[3]);
                    adj_reg[0] <= ONE_Q16;
                end else if (cfg.dims == 2'd2) begin
                    adj_reg[0] <= to_q16(geo_reg[7]);
                    adj_reg[1] <= neg32(to_q16(geo_reg[4]));
                    adj_reg[3] <= neg32(to_q16(geo_reg[6]));
                    adj_reg[4] <= to_q16(geo_reg[3]);
                end
            end
            BK_FADD: begin
                if (!fin_last_term) begin
                    facc_reg <= facc_new;
                    term_reg <= term_reg + 2'd1;
                end else begin
                    facc_reg <= '0;
                    term_reg <= '0;
                    case (phase_reg)
                        PH_COF: begin
                            if (cfg.dims == 2'd3) begin
                                adj_reg[idx_reg] <= fq;
                                if (idx_reg == 4'd8) begin
                                    phase_reg <= PH_DET;
                                    idx_reg   <= '0;
                                end else begin
                                    idx_reg <= idx_reg + 4'd1;
                                end
                            end else begin
                                det_reg <= fq;
                                idx_reg <= '0;
                            end
                        end
                        PH_DET: begin
                            det_reg <= fq;
                            idx_reg <= '0;
                        end
                        PH_MAP: begin
                            m_reg[idx_reg[1:0]] <= fq;
                            idx_reg             <= idx_reg + 4'd1;
                        end
                        default: begin
                            idx_reg <= '0;
                        end
                    endcase
                end
            end
            BK_DIV: begin
                if (div_skip) begin
                    idx_reg <= idx_reg + 4'd1;
                end
            end
            BK_DIVW: begin
                if (div_done) begin
                    inv_reg[idx_reg] <= div_q;
                    idx_reg          <= idx_reg + 4'd1;
                end
            end
            BK_EMIT: begin
                if (out_free) begin
                    res_reg.row_index <= {1'b0, row_reg};
                    res_reg.kind      <= kind_reg;
                    res_reg.last      <= 1'b0;
                    res_reg.val_e     <= '0;
                    res_reg.val_f     <= '0;
                    if (kind_reg == KIND_COORD) begin
                        res_reg.val_a <= xq_reg[0];
                        res_reg.val_b <= xq_reg[1];
                        res_reg.val_c <= xq_reg[2];
                        res_reg.val_d <= det_reg;
                        kind_reg      <= KIND_JAC;
                        row_reg       <= '0;
                    end else begin
                        res_reg.val_a <= re0;
                        res_reg.val_b <= re1;
                        res_reg.val_c <= re2;
                        res_reg.val_d <= '0;
                        if (row_reg == dm1) begin
                            kind_reg <= KIND_INV;
                            row_reg  <= '0;
                        end else begin
                            row_reg <= row_reg + 2'd1;
                        end
                    end
                end
            end
            BK_VLOAD: begin
                for (int k = 0; k < 3; k++) begin
                    vq_reg[k] <= to_q16(var_rd[k]);
                    g_reg[k]  <= to_q16(var_rd[3 + k]);
                    m_reg[k]  <= '0;
                end
                phase_reg <= PH_MAP;
                idx_reg   <= '0;
                term_reg  <= '0;
                facc_reg  <= '0;
            end
            BK_VEMIT: begin
                if (out_free) begin
                    res_reg.kind      <= KIND_VAR;
                    res_reg.row_index <= vj_reg;
                    res_reg.val_a     <= vq_reg[0];
                    res_reg.val_b     <= vq_reg[1];
                    res_reg.val_c     <= vq_reg[2];
                    res_reg.val_d     <= m_reg[0];
                    res_reg.val_e     <= m_reg[1];
                    res_reg.val_f     <= m_reg[2];
                    res_reg.last      <= var_last;
                    vj_reg            <= vj_reg + 3'd1;
                end
            end
            default: begin
                step_reg <= step_reg;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_res   = res_reg;

endmodule

// ===== tb/element_field_gradient_top_tb.sv =====
`timescale 1ns / 1ps
// element_field_gradient_top_tb: self-checking bench for element_field_gradient_top.
// Depends on efg_pkg and the RTL under rtl/core; a built-in predictor computes expected results.
module element_field_gradient_top_tb;
    import efg_pkg::*;

    localparam int  NODE_LIMIT = 32;
    localparam int  VAR_SLOTS  = 8;
    localparam int  DRAIN_CYC  = 400;   // extra wait after the last expected result is back
    localparam longint L_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint L_MIN   = 64'sh8000_0000_0000_0000;

    // content styles for generated items
    typedef enum int {CT_SMALL, CT_MIX, CT_MAX, CT_MIN, CT_FLAT} content_t;

    typedef struct {
        logic signed [31:0] sv;
        logic signed [31:0] d [3];
        logic signed [31:0] nd [3];
        logic signed [31:0] val;
        logic signed [31:0] rate;
        logic signed [31:0] acc;
        logic               last;
    } node_item_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic               cfg_index = 1'b0;
    logic [3:0]         cfg_wr_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_shape_value = '0, s_shape_d0 = '0, s_shape_d1 = '0, s_shape_d2 = '0;
    logic signed [31:0] s_node_x = '0, s_node_y = '0, s_node_z = '0;
    logic signed [31:0] s_var_value = '0, s_var_rate = '0, s_var_accel = '0;
    logic               s_last_of_element = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [1:0]         m_kind;
    logic [2:0]         m_row_index;
    logic signed [31:0] m_val_a, m_val_b, m_val_c, m_val_d, m_val_e, m_val_f;
    logic               m_last;

    element_field_gradient_top dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_shape_value(s_shape_value), .s_shape_d0(s_shape_d0), .s_shape_d1(s_shape_d1),
        .s_shape_d2(s_shape_d2), .s_node_x(s_node_x), .s_node_y(s_node_y),
        .s_node_z(s_node_z), .s_var_value(s_var_value), .s_var_rate(s_var_rate),
        .s_var_accel(s_var_accel), .s_last_of_element(s_last_of_element),
        .m_valid(m_valid), .m_ready(m_ready), .m_kind(m_kind), .m_row_index(m_row_index),
        .m_val_a(m_val_a), .m_val_b(m_val_b), .m_val_c(m_val_c), .m_val_d(m_val_d),
        .m_val_e(m_val_e), .m_val_f(m_val_f), .m_last(m_last)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Predictor state: Q32.32 sums, mirrored configuration, counters
    // ---------------------------------------------------------------------
    longint    coord_sum [3];
    longint    jac_sum [9];
    longint    value_sum [VAR_SLOTS];
    longint    rate_sum [VAR_SLOTS];
    longint    accel_sum [VAR_SLOTS];
    longint    grad_sum [3*VAR_SLOTS];
    int        var_pos;
    int        nodes_done;
    logic [1:0] dims_reg;
    logic [3:0] vars_reg;

    result_t   pending_results [$];   // expected results, oldest first
    int        mismatches;
    int        items_sent;
    bit        no_gaps;               // sender runs back to back when set
    bit        hold_request;          // asks the receiver for one long hold-off

    function automatic longint sum_sat(longint a, longint b);
        if (b > 0 && a > L_MAX - b) return L_MAX;
        if (b < 0 && a < L_MIN - b) return L_MIN;
        return a + b;
    endfunction

    // round half up, floor to Q16.16, clamp to 32 bits
    function automatic longint round_q16(longint v);
        longint r;
        r = sum_sat(v, 64'sd32768) >>> 16;
        if (r > 64'sd2147483647) return 64'sd2147483647;
        if (r < -64'sd2147483648) return -64'sd2147483648;
        return r;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint minor2(longint p, longint q, longint r, longint s);
        return round_q16(sum_sat(p * q, -(r * s)));
    endfunction

    function automatic int dims_eff();
        return (dims_reg == 2'd0) ? 1 : int'(dims_reg);
    endfunction

    function automatic int vars_eff();
        if (vars_reg == 4'd0) return 1;
        if (vars_reg > VAR_SLOTS) return VAR_SLOTS;
        return int'(vars_reg);
    endfunction

    function automatic void clear_sums();
        for (int i = 0; i < 3; i++) coord_sum[i] = 0;
        for (int i = 0; i < 9; i++) jac_sum[i] = 0;
        for (int i = 0; i < VAR_SLOTS; i++) begin
            value_sum[i] = 0;
            rate_sum[i] = 0;
            accel_sum[i] = 0;
        end
        for (int i = 0; i < 3*VAR_SLOTS; i++) grad_sum[i] = 0;
        var_pos = 0;
        nodes_done = 0;
    endfunction

    function automatic void push_result(logic [1:0] k, int row, longint v [6], bit lst);
        result_t r;
        r.kind = k;
        r.row_index = row[2:0];
        r.val_a = v[0][31:0];
        r.val_b = v[1][31:0];
        r.val_c = v[2][31:0];
        r.val_d = v[3][31:0];
        r.val_e = v[4][31:0];
        r.val_f = v[5][31:0];
        r.last = lst;
        pending_results.push_back(r);
    endfunction

    // invert the Jacobian, map gradients and queue every result of the element
    function automatic void finish_element();
        int     d, nv, total, n;
        longint a [9], adj [9], inv [9], v [6], g [3], det, s;
        d = dims_eff();
        nv = vars_eff();
        total = 1 + 2*d + nv;
        n = 0;
        for (int k = 0; k < 9; k++) begin
            a[k] = round_q16(jac_sum[k]);
            adj[k] = 0;
            inv[k] = 0;
        end
        if (d == 3) begin
            adj[0] = minor2(a[4], a[8], a[5], a[7]);
            adj[1] = minor2(a[2], a[7], a[1], a[8]);
            adj[2] = minor2(a[1], a[5], a[2], a[4]);
            adj[3] = minor2(a[5], a[6], a[3], a[8]);
            adj[4] = minor2(a[0], a[8], a[2], a[6]);
            adj[5] = minor2(a[2], a[3], a[0], a[5]);
            adj[6] = minor2(a[3], a[7], a[4], a[6]);
            adj[7] = minor2(a[1], a[6], a[0], a[7]);
            adj[8] = minor2(a[0], a[4], a[1], a[3]);
            det = round_q16(sum_sat(sum_sat(a[0]*adj[0], a[1]*adj[3]), a[2]*adj[6]));
        end else if (d == 2) begin
            det = minor2(a[0], a[4], a[1], a[3]);
            adj[0] = a[4];
            adj[1] = (a[1] == -64'sd2147483648) ? 64'sd2147483647 : -a[1];
            adj[3] = (a[3] == -64'sd2147483648) ? 64'sd2147483647 : -a[3];
            adj[4] = a[0];
        end else begin
            det = a[0];
            adj[0] = 65536;
        end
        // singular Jacobian leaves the inverse at zero
        if (det != 0)
            for (int k = 0; k < 9; k++) inv[k] = clamp32((adj[k] * 65536) / det);

        for (int i = 0; i < 3; i++) v[i] = round_q16(coord_sum[i]);
        v[3] = det;
        v[4] = 0;
        v[5] = 0;
        n++;
        push_result(KIND_COORD, 0, v, n == total);
        for (int r = 0; r < d; r++) begin
            for (int c = 0; c < 6; c++) v[c] = (c < d) ? a[3*r+c] : 0;
            n++;
            push_result(KIND_JAC, r, v, n == total);
        end
        for (int r = 0; r < d; r++) begin
            for (int c = 0; c < 6; c++) v[c] = (c < d) ? inv[3*r+c] : 0;
            n++;
            push_result(KIND_INV, r, v, n == total);
        end
        for (int j = 0; j < nv; j++) begin
            for (int k = 0; k < 3; k++) g[k] = round_q16(grad_sum[3*j+k]);
            v[0] = round_q16(value_sum[j]);
            v[1] = round_q16(rate_sum[j]);
            v[2] = round_q16(accel_sum[j]);
            for (int c = 0; c < 3; c++) begin
                s = 0;
                if (c < d) begin
                    for (int k = 0; k < d; k++) s = sum_sat(s, inv[3*k+c] * g[k]);
                    v[3+c] = round_q16(s);
                end else begin
                    v[3+c] = 0;
                end
            end
            n++;
            push_result(KIND_VAR, j, v, n == total);
        end
    endfunction

    // fold one accepted transfer into the sums
    function automatic void accumulate_item(node_item_t it);
        int     nv, j;
        longint sv;
        nv = vars_eff();
        sv = it.sv;
        if (var_pos >= nv) var_pos = 0;   // vars shrank mid-node: start a new node
        j = var_pos;
        if (nodes_done < NODE_LIMIT) begin
            if (j == 0)
                for (int r = 0; r < 3; r++) begin
                    coord_sum[r] = sum_sat(coord_sum[r], sv * longint'(it.nd[r]));
                    for (int c = 0; c < 3; c++)
                        jac_sum[3*r+c] = sum_sat(jac_sum[3*r+c],
                                                 longint'(it.d[c]) * longint'(it.nd[r]));
                end
            value_sum[j] = sum_sat(value_sum[j], sv * longint'(it.val));
            rate_sum[j] = sum_sat(rate_sum[j], sv * longint'(it.rate));
            accel_sum[j] = sum_sat(accel_sum[j], sv * longint'(it.acc));
            for (int c = 0; c < 3; c++)
                grad_sum[3*j+c] = sum_sat(grad_sum[3*j+c],
                                          longint'(it.d[c]) * longint'(it.val));
        end
        var_pos = j + 1;
        if (var_pos >= nv) begin
            var_pos = 0;
            if (nodes_done < NODE_LIMIT) nodes_done++;
        end
        if (it.last) begin
            finish_element();
            clear_sums();
        end
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 85) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 70);
    endfunction

    function automatic logic signed [31:0] pick_q(content_t ct);
        int p;
        case (ct)
            CT_MAX: return Q_MAX;
            CT_MIN: return Q_MIN;
            CT_SMALL: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            default: begin
                p = $urandom_range(0, 9);
                if (p < 2) return $urandom;
                if (p == 2) begin
                    case ($urandom_range(0, 4))
                        0: return Q_MAX;
                        1: return Q_MIN;
                        2: return 32'sd0;
                        3: return ONE_Q16;
                        default: return -ONE_Q16;
                    endcase
                end
                return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
            end
        endcase
    endfunction

    // one transfer on the input channel; the predictor sees it on acceptance
    task automatic send_item(node_item_t it);
        int g;
        g = no_gaps ? 0 : gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_shape_value <= it.sv;
        s_shape_d0 <= it.d[0];
        s_shape_d1 <= it.d[1];
        s_shape_d2 <= it.d[2];
        s_node_x <= it.nd[0];
        s_node_y <= it.nd[1];
        s_node_z <= it.nd[2];
        s_var_value <= it.val;
        s_var_rate <= it.rate;
        s_var_accel <= it.acc;
        s_last_of_element <= it.last;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        accumulate_item(it);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic go_quiet();
        s_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // an element of whole nodes; last_at < 0 marks the final item, else that item index
    task automatic send_element(int nodes, content_t ct, int last_at = -1);
        node_item_t it;
        int         nv, total;
        nv = vars_eff();
        total = nodes * nv;
        for (int i = 0; i < total; i++) begin
            if (i % nv == 0) begin
                it.sv = pick_q(ct);
                for (int c = 0; c < 3; c++) begin
                    it.d[c] = pick_q(ct);
                    it.nd[c] = (ct == CT_FLAT) ? 32'sd0 : pick_q(ct);
                end
            end
            it.val = pick_q(ct);
            it.rate = pick_q(ct);
            it.acc = pick_q(ct);
            it.last = (last_at < 0) ? (i == total - 1) : (i == last_at);
            send_item(it);
            if (it.last) break;
        end
        go_quiet();
    endtask

    // wait until every expected result is back and the back end has settled
    task automatic drain();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [3:0] data);
        cfg_index <= idx;
        cfg_wr_data <= data;
        cfg_wr_en <= 1'b1;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_DIMENSIONS) dims_reg = data[1:0];
        else vars_reg = data;
        @(negedge aclk);
    endtask

    task automatic set_shape(logic [3:0] dims, logic [3:0] nvars);
        drain();
        write_reg(REG_DIMENSIONS, dims);
        write_reg(REG_VARS, nvars);
    endtask

    // ---------------------------------------------------------------------
    // Result side: random stalls, one long hold-off on request
    // ---------------------------------------------------------------------
    initial begin
        int g;
        @(negedge aclk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (600) @(negedge aclk);
            end
            g = gap_len();
            if (g > 0) begin
                m_ready <= 1'b0;
                repeat (g) @(negedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
    end

    // compare every result transfer with the oldest expectation
    always @(posedge aclk) begin
        result_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_kind, m_row_index, m_val_a, m_val_b, m_val_c, m_val_d, m_val_e,
                    m_val_f, m_last};
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t unexpected result kind=%0d row=%0d", $realtime, m_kind,
                             m_row_index);
            end else begin
                want = pending_results.pop_front();
                if (got.kind !== want.kind || got.row_index !== want.row_index ||
                    got.val_a !== want.val_a || got.val_b !== want.val_b ||
                    got.val_c !== want.val_c || got.val_d !== want.val_d ||
                    got.val_e !== want.val_e || got.val_f !== want.val_f ||
                    got.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t mismatch exp k%0d r%0d %h %h %h %h %h %h l%0d",
                                 $realtime, want.kind, want.row_index, want.val_a,
                                 want.val_b, want.val_c, want.val_d, want.val_e,
                                 want.val_f, want.last);
                        $display("%0t          got k%0d r%0d %h %h %h %h %h %h l%0d",
                                 $realtime, got.kind, got.row_index, got.val_a,
                                 got.val_b, got.val_c, got.val_d, got.val_e,
                                 got.val_f, got.last);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------
    task automatic test_reset_shape();
        send_element(2, CT_SMALL);      // dims 3, vars 3 straight from reset
    endtask

    task automatic test_extremes();
        set_shape(4'd3, 4'd1);
        send_element(2, CT_MAX);
        send_element(2, CT_MIN);
        send_element(1, CT_FLAT);       // all coordinates zero: singular Jacobian
    endtask

    task automatic test_dims_sweep();
        for (int d = 0; d < 4; d++) begin
            set_shape(d[3:0], 4'd1);
            send_element(2, CT_MIX);
        end
        set_shape(4'd2, 4'd8);          // widest variable count
        send_element(1, CT_SMALL);
    endtask

    task automatic test_vars_out_of_range();
        set_shape(4'd1, 4'd0);          // acts as one variable
        send_element(2, CT_SMALL);
        set_shape(4'd3, 4'd15);         // acts as eight
        send_element(1, CT_SMALL);
    endtask

    task automatic test_early_last();
        set_shape(4'd3, 4'd3);
        send_element(2, CT_SMALL, 4);   // last mark in the middle of a node
    endtask

    task automatic test_node_overflow();
        set_shape(4'd2, 4'd1);
        send_element(NODE_LIMIT + 3, CT_SMALL);
    endtask

    task automatic test_vars_shrink();
        node_item_t it;
        set_shape(4'd3, 4'd3);
        it.sv = pick_q(CT_SMALL);
        for (int c = 0; c < 3; c++) begin
            it.d[c] = pick_q(CT_SMALL);
            it.nd[c] = pick_q(CT_SMALL);
        end
        it.last = 1'b0;
        for (int i = 0; i < 2; i++) begin   // two items of a node, no last
            it.val = pick_q(CT_SMALL);
            it.rate = pick_q(CT_SMALL);
            it.acc = pick_q(CT_SMALL);
            send_item(it);
        end
        go_quiet();
        drain();
        write_reg(REG_VARS, 4'd2);      // counter now at the new count
        send_element(2, CT_SMALL);
    endtask

    task automatic test_backpressure();
        set_shape(4'd1, 4'd1);
        no_gaps = 1'b1;
        hold_request = 1'b1;            // receiver holds while short elements pile up
        for (int i = 0; i < 20; i++) send_element(1, CT_SMALL);
        no_gaps = 1'b0;
    endtask

    task automatic test_random(int item_goal);
        int stop_at, el;
        stop_at = items_sent + item_goal;
        el = 0;
        while (items_sent < stop_at) begin
            if (el % 8 == 0) set_shape($urandom_range(0, 3), $urandom_range(0, 15));
            no_gaps = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 9) == 0)
                send_element($urandom_range(1, 3), CT_MIX, $urandom_range(0, 8));
            else
                send_element($urandom_range(1, 4), ($urandom_range(0, 1) != 0) ? CT_MIX
                                                                               : CT_SMALL);
            el++;
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        mismatches = 0;
        items_sent = 0;
        no_gaps = 1'b0;
        hold_request = 1'b0;
        dims_reg = 2'd3;
        vars_reg = 4'd3;
        clear_sums();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_shape();
        test_extremes();
        test_dims_sweep();
        test_vars_out_of_range();
        test_early_last();
        test_node_overflow();
        test_vars_shrink();
        test_backpressure();
        test_random(250);

        drain();
        if (mismatches == 0 && pending_results.size() == 0)
            $display("element_field_gradient_top_tb: PASS");
        else
            $display("element_field_gradient_top_tb: FAIL");
        $finish;
    end

    // guard against a hung handshake
    initial begin
        #8_000_000;
        $display("element_field_gradient_top_tb: FAIL");
        $finish;
    end

endmodule
